>>> hdl/rgbhsv_pkg.sv
// ----------------------------------------------------------------------------
// rgbhsv_pkg
// shared constants and types for the rgb to hsv converter pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rgbhsv_pkg;

    // restoring divide steps done in one pipeline stage
    localparam int DIV_STEPS = 4;

    // which component holds the maximum, red wins ties, then green
    typedef enum logic [1:0] {
        SECT_RED,
        SECT_GREEN,
        SECT_BLUE
    } sector_t;

endpackage

`default_nettype wire

>>> hdl/rgbhsv_minmax.sv
// ----------------------------------------------------------------------------
// rgbhsv_minmax
// first stage: maximum, minimum, delta and hue sector of one pixel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgbhsv_minmax #(
    parameter int COMPONENT_BITS = 8
) (
    input  logic                      clk,
    input  logic                      en,
    input  logic [COMPONENT_BITS-1:0] red,
    input  logic [COMPONENT_BITS-1:0] green,
    input  logic [COMPONENT_BITS-1:0] blue,
    output logic [COMPONENT_BITS-1:0] red_p,
    output logic [COMPONENT_BITS-1:0] green_p,
    output logic [COMPONENT_BITS-1:0] blue_p,
    output logic [COMPONENT_BITS-1:0] maxv,
    output logic [COMPONENT_BITS-1:0] delta,
    output rgbhsv_pkg::sector_t       sector
);

    import rgbhsv_pkg::*;

    localparam int CW = COMPONENT_BITS;

    logic [CW-1:0] red_reg;
    logic [CW-1:0] green_reg;
    logic [CW-1:0] blue_reg;
    logic [CW-1:0] maxv_reg;
    logic [CW-1:0] delta_reg;
    sector_t       sector_reg;

    logic [CW-1:0] maxv_next;
    logic [CW-1:0] minv;
    logic [CW-1:0] delta_next;
    sector_t       sector_next;

    always_comb
    begin
        if (red >= green && red >= blue)
        begin
            sector_next = SECT_RED;
            maxv_next   = red;
        end
        else if (green >= blue)
        begin
            sector_next = SECT_GREEN;
            maxv_next   = green;
        end
        else
        begin
            sector_next = SECT_BLUE;
            maxv_next   = blue;
        end

        if (red <= green && red <= blue)
        begin
            minv = red;
        end
        else if (green <= blue)
        begin
            minv = green;
        end
        else
        begin
            minv = blue;
        end

        delta_next = maxv_next - minv;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            red_reg    <= red;
            green_reg  <= green;
            blue_reg   <= blue;
            maxv_reg   <= maxv_next;
            delta_reg  <= delta_next;
            sector_reg <= sector_next;
        end
    end

    assign red_p   = red_reg;
    assign green_p = green_reg;
    assign blue_p  = blue_reg;
    assign maxv    = maxv_reg;
    assign delta   = delta_reg;
    assign sector  = sector_reg;

endmodule

`default_nettype wire

>>> hdl/rgbhsv_numer.sv
// ----------------------------------------------------------------------------
// rgbhsv_numer
// second stage: hue numerator and divisor, saturation dividend and divisor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgbhsv_numer #(
    parameter int COMPONENT_BITS = 8
) (
    input  logic                      clk,
    input  logic                      en,
    input  logic [COMPONENT_BITS-1:0] red,
    input  logic [COMPONENT_BITS-1:0] green,
    input  logic [COMPONENT_BITS-1:0] blue,
    input  logic [COMPONENT_BITS-1:0] maxv,
    input  logic [COMPONENT_BITS-1:0] delta,
    input  rgbhsv_pkg::sector_t       sector,
    output logic [COMPONENT_BITS+2:0] hue_rem,
    output logic [COMPONENT_BITS+2:0] hue_div,
    output logic [COMPONENT_BITS-1:0] sat_rem,
    output logic [COMPONENT_BITS-1:0] sat_low,
    output logic [COMPONENT_BITS-1:0] sat_div,
    output logic [COMPONENT_BITS-1:0] bright
);

    import rgbhsv_pkg::*;

    localparam int CW = COMPONENT_BITS;
    localparam int DW = CW + 3;
    localparam int NW = CW + 4;

    logic [DW-1:0]   hue_rem_reg;
    logic [DW-1:0]   hue_div_reg;
    logic [CW-1:0]   sat_rem_reg;
    logic [CW-1:0]   sat_low_reg;
    logic [CW-1:0]   sat_div_reg;
    logic [CW-1:0]   bright_reg;

    logic [DW-1:0]   hue_rem_next;
    logic [DW-1:0]   hue_div_next;
    logic [CW-1:0]   sat_rem_next;
    logic [CW-1:0]   sat_low_next;
    logic [CW-1:0]   sat_div_next;

    logic            gray;
    logic [DW-1:0]   d6;
    logic [NW-1:0]   ext_r;
    logic [NW-1:0]   ext_g;
    logic [NW-1:0]   ext_b;
    logic [NW-1:0]   ext_d2;
    logic [NW-1:0]   ext_d4;
    logic [NW-1:0]   ext_d6;
    logic [NW-1:0]   num;
    logic [2*CW-1:0] sat_x;

    always_comb
    begin
        gray   = (delta == '0);
        d6     = {1'b0, delta, 2'b00} + {2'b00, delta, 1'b0};
        ext_r  = {4'b0000, red};
        ext_g  = {4'b0000, green};
        ext_b  = {4'b0000, blue};
        ext_d2 = {3'b000, delta, 1'b0};
        ext_d4 = {2'b00, delta, 2'b00};
        ext_d6 = {1'b0, d6};

        // numerator over 6*delta is always in [0, 6*delta)
        unique case (sector)
            SECT_RED:
            begin
                if (green >= blue)
                begin
                    num = ext_g - ext_b;
                end
                else
                begin
                    num = ext_d6 + ext_g - ext_b;
                end
            end
            SECT_GREEN: num = ext_d2 + ext_b - ext_r;
            SECT_BLUE:  num = ext_d4 + ext_r - ext_g;
            default:    num = '0;
        endcase

        // delta * (2^cw - 1); the high half is already below max
        sat_x = {delta, {CW{1'b0}}} - {{CW{1'b0}}, delta};

        // gray: all-ones divisor over a zero dividend gives zero quotients
        hue_rem_next = gray ? '0 : num[DW-1:0];
        hue_div_next = gray ? '1 : d6;
        sat_rem_next = gray ? '0 : sat_x[2*CW-1:CW];
        sat_low_next = gray ? '0 : sat_x[CW-1:0];
        sat_div_next = gray ? '1 : maxv;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hue_rem_reg <= hue_rem_next;
            hue_div_reg <= hue_div_next;
            sat_rem_reg <= sat_rem_next;
            sat_low_reg <= sat_low_next;
            sat_div_reg <= sat_div_next;
            bright_reg  <= maxv;
        end
    end

    assign hue_rem = hue_rem_reg;
    assign hue_div = hue_div_reg;
    assign sat_rem = sat_rem_reg;
    assign sat_low = sat_low_reg;
    assign sat_div = sat_div_reg;
    assign bright  = bright_reg;

endmodule

`default_nettype wire

>>> hdl/rgbhsv_div_stage.sv
// ----------------------------------------------------------------------------
// rgbhsv_div_stage
// one divider stage: a few restoring steps for both hue and saturation
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgbhsv_div_stage #(
    parameter int COMPONENT_BITS = 8,
    parameter int HUE_BITS       = 16,
    parameter int STAGE_IDX      = 0
) (
    input  logic                      clk,
    input  logic                      en,
    input  logic [COMPONENT_BITS+2:0] hue_rem,
    input  logic [COMPONENT_BITS+2:0] hue_div,
    input  logic [HUE_BITS-1:0]       hue_quo,
    input  logic [COMPONENT_BITS-1:0] sat_rem,
    input  logic [COMPONENT_BITS-1:0] sat_low,
    input  logic [COMPONENT_BITS-1:0] sat_div,
    input  logic [COMPONENT_BITS-1:0] sat_quo,
    input  logic [COMPONENT_BITS-1:0] bright,
    output logic [COMPONENT_BITS+2:0] hue_rem_p,
    output logic [COMPONENT_BITS+2:0] hue_div_p,
    output logic [HUE_BITS-1:0]       hue_quo_p,
    output logic [COMPONENT_BITS-1:0] sat_rem_p,
    output logic [COMPONENT_BITS-1:0] sat_low_p,
    output logic [COMPONENT_BITS-1:0] sat_div_p,
    output logic [COMPONENT_BITS-1:0] sat_quo_p,
    output logic [COMPONENT_BITS-1:0] bright_p
);

    import rgbhsv_pkg::*;

    localparam int CW = COMPONENT_BITS;
    localparam int HW = HUE_BITS;
    localparam int DW = CW + 3;

    logic [DW-1:0] hue_rem_reg;
    logic [DW-1:0] hue_div_reg;
    logic [HW-1:0] hue_quo_reg;
    logic [CW-1:0] sat_rem_reg;
    logic [CW-1:0] sat_low_reg;
    logic [CW-1:0] sat_div_reg;
    logic [CW-1:0] sat_quo_reg;
    logic [CW-1:0] bright_reg;

    logic [DW-1:0] h_rem;
    logic [DW:0]   h_t;
    logic [DW:0]   h_diff;
    logic [HW-1:0] h_q;
    logic [CW-1:0] s_rem;
    logic [CW-1:0] s_low;
    logic [CW:0]   s_t;
    logic [CW:0]   s_diff;
    logic [CW-1:0] s_q;

    always_comb
    begin
        h_rem  = hue_rem;
        h_q    = hue_quo;
        s_rem  = sat_rem;
        s_low  = sat_low;
        s_q    = sat_quo;
        h_t    = '0;
        h_diff = '0;
        s_t    = '0;
        s_diff = '0;

        for (int k = 0; k < DIV_STEPS; k++)
        begin
            // hue: fraction bits of rem / div, rem stays below div
            if (STAGE_IDX * DIV_STEPS + k < HW)
            begin
                h_t    = {h_rem, 1'b0};
                h_diff = h_t - {1'b0, hue_div};
                if (h_t >= {1'b0, hue_div})
                begin
                    h_rem = h_diff[DW-1:0];
                    h_q   = {h_q[HW-2:0], 1'b1};
                end
                else
                begin
                    h_rem = h_t[DW-1:0];
                    h_q   = {h_q[HW-2:0], 1'b0};
                end
            end

            // saturation: long division, low dividend bits shift in msb first
            if (STAGE_IDX * DIV_STEPS + k < CW)
            begin
                s_t    = {s_rem, s_low[CW-1]};
                s_diff = s_t - {1'b0, sat_div};
                s_low  = {s_low[CW-2:0], 1'b0};
                if (s_t >= {1'b0, sat_div})
                begin
                    s_rem = s_diff[CW-1:0];
                    s_q   = {s_q[CW-2:0], 1'b1};
                end
                else
                begin
                    s_rem = s_t[CW-1:0];
                    s_q   = {s_q[CW-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hue_rem_reg <= h_rem;
            hue_div_reg <= hue_div;
            hue_quo_reg <= h_q;
            sat_rem_reg <= s_rem;
            sat_low_reg <= s_low;
            sat_div_reg <= sat_div;
            sat_quo_reg <= s_q;
            bright_reg  <= bright;
        end
    end

    assign hue_rem_p = hue_rem_reg;
    assign hue_div_p = hue_div_reg;
    assign hue_quo_p = hue_quo_reg;
    assign sat_rem_p = sat_rem_reg;
    assign sat_low_p = sat_low_reg;
    assign sat_div_p = sat_div_reg;
    assign sat_quo_p = sat_quo_reg;
    assign bright_p  = bright_reg;

endmodule

`default_nettype wire

>>> hdl/rgb_to_hsv_converter_core.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_core
// stages: rgbhsv_minmax, rgbhsv_numer, then the chain of rgbhsv_div_stage stages
// throughput: one word per cycle while out_stall is low; each divider stage retires 4 quotient bits
// a stall holds each full stage with no empty stage after it, empty stages still fill
// reset clears the stage valid bits only, data registers are not reset
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_hsv_converter_core #(
    parameter int COMPONENT_BITS = 8,
    parameter int HUE_BITS       = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [COMPONENT_BITS-1:0] red,
    input  logic [COMPONENT_BITS-1:0] green,
    input  logic [COMPONENT_BITS-1:0] blue,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [HUE_BITS-1:0]       hue,
    output logic [COMPONENT_BITS-1:0] saturation,
    output logic [COMPONENT_BITS-1:0] brightness
);

    import rgbhsv_pkg::*;

    localparam int CW    = COMPONENT_BITS;
    localparam int HW    = HUE_BITS;
    localparam int DW    = CW + 3;
    localparam int STEPS = (HW > CW) ? HW : CW;
    localparam int NDIV  = (STEPS + DIV_STEPS - 1) / DIV_STEPS;
    localparam int NST   = NDIV + 2;

    logic [NST-1:0] v_reg;
    logic [NST-1:0] v_next;
    logic [NST-1:0] en;

    logic [CW-1:0] s1_red;
    logic [CW-1:0] s1_green;
    logic [CW-1:0] s1_blue;
    logic [CW-1:0] s1_maxv;
    logic [CW-1:0] s1_delta;
    sector_t       s1_sector;

    logic [DW-1:0] h_rem  [NDIV+1];
    logic [DW-1:0] h_div  [NDIV+1];
    logic [HW-1:0] h_quo  [NDIV+1];
    logic [CW-1:0] s_rem  [NDIV+1];
    logic [CW-1:0] s_low  [NDIV+1];
    logic [CW-1:0] s_div  [NDIV+1];
    logic [CW-1:0] s_quo  [NDIV+1];
    logic [CW-1:0] bright [NDIV+1];

    // a stage moves when it is empty or the one after it moves
    always_comb
    begin
        en[NST-1] = !v_reg[NST-1] || !out_stall;
        for (int i = NST - 2; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
        v_next[0] = en[0] ? in_valid : v_reg[0];
        for (int i = 1; i < NST; i++)
        begin
            v_next[i] = en[i] ? v_reg[i-1] : v_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    rgbhsv_minmax #(
        .COMPONENT_BITS(CW)
    ) u_minmax (
        .clk     (clk),
        .en      (en[0]),
        .red     (red),
        .green   (green),
        .blue    (blue),
        .red_p   (s1_red),
        .green_p (s1_green),
        .blue_p  (s1_blue),
        .maxv    (s1_maxv),
        .delta   (s1_delta),
        .sector  (s1_sector)
    );

    rgbhsv_numer #(
        .COMPONENT_BITS(CW)
    ) u_numer (
        .clk     (clk),
        .en      (en[1]),
        .red     (s1_red),
        .green   (s1_green),
        .blue    (s1_blue),
        .maxv    (s1_maxv),
        .delta   (s1_delta),
        .sector  (s1_sector),
        .hue_rem (h_rem[0]),
        .hue_div (h_div[0]),
        .sat_rem (s_rem[0]),
        .sat_low (s_low[0]),
        .sat_div (s_div[0]),
        .bright  (bright[0])
    );

    // quotients start empty and fill from the lsb side
    assign h_quo[0] = '0;
    assign s_quo[0] = '0;

    for (genvar i = 0; i < NDIV; i++)
    begin : g_div
        rgbhsv_div_stage #(
            .COMPONENT_BITS (CW),
            .HUE_BITS       (HW),
            .STAGE_IDX      (i)
        ) u_div_stage (
            .clk       (clk),
            .en        (en[i+2]),
            .hue_rem   (h_rem[i]),
            .hue_div   (h_div[i]),
            .hue_quo   (h_quo[i]),
            .sat_rem   (s_rem[i]),
            .sat_low   (s_low[i]),
            .sat_div   (s_div[i]),
            .sat_quo   (s_quo[i]),
            .bright    (bright[i]),
            .hue_rem_p (h_rem[i+1]),
            .hue_div_p (h_div[i+1]),
            .hue_quo_p (h_quo[i+1]),
            .sat_rem_p (s_rem[i+1]),
            .sat_low_p (s_low[i+1]),
            .sat_div_p (s_div[i+1]),
            .sat_quo_p (s_quo[i+1]),
            .bright_p  (bright[i+1])
        );
    end

    assign in_stall   = !en[0];
    assign out_valid  = v_reg[NST-1];
    assign hue        = h_quo[NDIV];
    assign saturation = s_quo[NDIV];
    assign brightness = bright[NDIV];

`ifndef ASSERT_OFF
    // zero saturation only happens for gray, which has zero hue
    a_gray_hue: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturation == '0 |-> hue == '0)
        else $error("zero saturation with nonzero hue");

    // a free output never backs up into the input
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input stalled while output is free");

    // input only stalls when every stage holds a word
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> &v_reg)
        else $error("input stalled with an empty stage");
`endif

endmodule

`default_nettype wire

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for rgb_to_hsv_converter_core: pixels go in through the
// valid/stall channel with random gaps, a local hsv predictor queues the
// expected word, and a checker compares every result word field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import rgbhsv_pkg::*;

    localparam int CB   = 8;
    localparam int HB   = 16;
    localparam int FULL = (1 << CB) - 1;

    typedef struct packed {
        logic [HB-1:0] hue;
        logic [CB-1:0] sat;
        logic [CB-1:0] val;
    } hsv_t;

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_stall;
    logic [CB-1:0] red;
    logic [CB-1:0] green;
    logic [CB-1:0] blue;
    logic          out_valid;
    logic          out_stall;
    logic [HB-1:0] hue;
    logic [CB-1:0] saturation;
    logic [CB-1:0] brightness;

    hsv_t pending_hsv[$];
    int   n_sent;
    int   n_checked;
    int   n_fail;
    bit   tx_idle;
    bit   rx_idle;

    rgb_to_hsv_converter_core #(
        .COMPONENT_BITS(CB),
        .HUE_BITS(HB)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .red(red),
        .green(green),
        .blue(blue),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .hue(hue),
        .saturation(saturation),
        .brightness(brightness)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // hue as an exact fraction of a turn, truncated, red wins max ties then green
    function automatic hsv_t convert_pixel(input logic [CB-1:0] r, g, b);
        hsv_t              res;
        sector_t           sect;
        int unsigned       mx;
        int unsigned       mn;
        int unsigned       d;
        int unsigned       num;
        longint unsigned   turn;
        mx = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        mn = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d = mx - mn;
        res.val = mx[CB-1:0];
        if (d == 0)
        begin
            res.hue = '0;
            res.sat = '0;
        end
        else
        begin
            res.sat = CB'((d * FULL) / mx);
            if (mx == r)
                sect = SECT_RED;
            else if (mx == g)
                sect = SECT_GREEN;
            else
                sect = SECT_BLUE;
            case (sect)
                SECT_RED:   num = (g >= b) ? (g - b) : (6 * d + g - b);
                SECT_GREEN: num = 2 * d + b - r;
                default:    num = 4 * d + r - g;
            endcase
            turn = num;
            turn = (turn << HB) / (6 * d);
            res.hue = turn[HB-1:0];
        end
        return res;
    endfunction

    function automatic int draw_gap(input bit enabled);
        if (!enabled || $urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 18);
    endfunction

    function automatic logic [CB-1:0] rand_comp();
        return CB'($urandom_range(0, FULL));
    endfunction

    task automatic send_pixel(input logic [CB-1:0] r, g, b);
        int gap;
        gap = draw_gap(tx_idle);
        @(negedge clk);
        repeat (gap)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        red      <= r;
        green    <= g;
        blue     <= b;
        do @(posedge clk); while (in_stall);
        pending_hsv.push_back(convert_pixel(r, g, b));
        n_sent++;
    endtask

    task automatic stop_sending();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic wait_results_done(input int limit);
        int waited;
        waited = 0;
        while (pending_hsv.size() != 0 && waited < limit)
        begin
            @(posedge clk);
            waited++;
        end
    endtask

    task automatic test_directed();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        send_pixel(8'd0,   8'd0,   8'd0);    // black, gray
        send_pixel(8'd255, 8'd255, 8'd255);  // white, gray
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd255, 8'd0,   8'd0);
        send_pixel(8'd0,   8'd255, 8'd0);
        send_pixel(8'd0,   8'd0,   8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);    // red and green tie
        send_pixel(8'd0,   8'd255, 8'd255);  // green and blue tie
        send_pixel(8'd255, 8'd0,   8'd255);  // red and blue tie, hue wraps
        send_pixel(8'd255, 8'd0,   8'd1);    // red max, smallest wrap
        send_pixel(8'd1,   8'd0,   8'd0);    // tiny max, full saturation
        send_pixel(8'd0,   8'd1,   8'd1);
        send_pixel(8'd255, 8'd254, 8'd254);  // nearly gray
        send_pixel(8'd254, 8'd255, 8'd0);
        send_pixel(8'd1,   8'd2,   8'd3);
        send_pixel(8'd200, 8'd100, 8'd50);
        send_pixel(8'd85,  8'd170, 8'd255);
        send_pixel(8'd255, 8'd1,   8'd0);
    endtask

    task automatic test_random_pixels(input int count);
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        repeat (count)
            send_pixel(rand_comp(), rand_comp(), rand_comp());
    endtask

    // hold the input off until the pipe has fully emptied, then resume
    task automatic test_drain_pause();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        repeat (20)
            send_pixel(rand_comp(), rand_comp(), rand_comp());
        stop_sending();
        wait_results_done(5000);
        repeat (20)
            send_pixel(rand_comp(), rand_comp(), rand_comp());
    endtask

    task automatic test_ties_and_grays(input int count);
        logic [CB-1:0] a;
        logic [CB-1:0] c;
        int            base;
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        repeat (count)
        begin
            a = rand_comp();
            c = CB'($urandom_range(0, a));
            base = a;
            case ($urandom_range(0, 4))
                0: send_pixel(a, a, c);
                1: send_pixel(c, a, a);
                2: send_pixel(a, c, a);
                3: send_pixel(a,
                              CB'((base + $urandom_range(0, 2) > FULL) ? FULL
                                  : base + $urandom_range(0, 2)),
                              CB'((base < 2) ? 0 : base - $urandom_range(0, 2)));
                default: send_pixel(($urandom_range(0, 1) != 0) ? CB'(FULL) : '0,
                                    rand_comp(), rand_comp());
            endcase
        end
    endtask

    task automatic test_full_rate(input int count);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        repeat (count)
            send_pixel(rand_comp(), rand_comp(), rand_comp());
    endtask

    task automatic test_one_side_idle(input int count);
        tx_idle = 1'b1;
        rx_idle = 1'b0;
        repeat (count / 2)
            send_pixel(rand_comp(), rand_comp(), rand_comp());
        tx_idle = 1'b0;
        rx_idle = 1'b1;
        repeat (count / 2)
            send_pixel(rand_comp(), rand_comp(), rand_comp());
    endtask

    // result checker, the receive side holds out_stall for a random gap before each word when rx_idle is set
    initial
    begin
        hsv_t exp;
        int   stall_n;
        out_stall = 1'b0;
        forever
        begin
            stall_n = draw_gap(rx_idle);
            @(negedge clk);
            repeat (stall_n)
            begin
                out_stall <= 1'b1;
                @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!(rst_n && out_valid));
            if (pending_hsv.size() == 0)
            begin
                $error("result word with nothing expected: hue %0d sat %0d val %0d",
                       hue, saturation, brightness);
                n_fail++;
            end
            else
            begin
                exp = pending_hsv.pop_front();
                n_checked++;
                if (hue !== exp.hue)
                begin
                    $error("hue mismatch: expected %0d, got %0d", exp.hue, hue);
                    n_fail++;
                end
                if (saturation !== exp.sat)
                begin
                    $error("saturation mismatch: expected %0d, got %0d",
                           exp.sat, saturation);
                    n_fail++;
                end
                if (brightness !== exp.val)
                begin
                    $error("brightness mismatch: expected %0d, got %0d",
                           exp.val, brightness);
                    n_fail++;
                end
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        n_sent    = 0;
        n_checked = 0;
        n_fail    = 0;
        tx_idle   = 1'b0;
        rx_idle   = 1'b0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        red       = '0;
        green     = '0;
        blue      = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random_pixels(500);
        test_drain_pause();
        test_ties_and_grays(300);
        test_full_rate(260);
        test_one_side_idle(200);

        stop_sending();
        wait_results_done(20000);
        repeat (20) @(posedge clk);
        if (pending_hsv.size() != 0)
        begin
            $error("%0d expected result words never arrived", pending_hsv.size());
            n_fail++;
        end

        $display("sent %0d pixels (extremes, ties, grays, random) under mixed stalls,",
                 n_sent);
        $display("checked %0d hsv words, %0d field errors", n_checked, n_fail);
        if (n_fail == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> sim.f
hdl/rgbhsv_pkg.sv
hdl/rgbhsv_minmax.sv
hdl/rgbhsv_numer.sv
hdl/rgbhsv_div_stage.sv
hdl/rgb_to_hsv_converter_core.sv
tb/tb.sv
